>>> design/nfa_pkg.sv
// Shared types, codes and sizing helpers for the NV21 to ARGB converter.
// No dependencies; every other design file imports this package.
package nfa_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RST_WIDTH      = 640;
    localparam int RST_HEIGHT     = 480;
    localparam int QUEUE_DEPTH    = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // op codes on s_tuser
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_EMIT  = 1'b1;

    localparam logic [7:0]         ALPHA       = 8'hFF;
    localparam logic signed [11:0] CHROMA_BIAS = 12'sd128;

    localparam int CMD_KIND_W = 2;
    typedef enum logic [CMD_KIND_W-1:0] {
        CMD_LUMA_WR,
        CMD_CHROMA_WR,
        CMD_EMIT
    } cmd_kind_t;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // clamp to 2..maxv, then force even
    function automatic int fit_size(input int v, input int maxv);
        int r;
        if (v < 2)
            r = 2;
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        r = r & ~1;
        if (r < 2)
            r = 2;
        return r;
    endfunction

    // kind + luma addr + chroma index + bank + byte + last
    function automatic int entry_bits(input int la, input int ca);
        return CMD_KIND_W + la + ca + 1 + 8 + 1;
    endfunction

endpackage

>>> design/nfa_front.sv
// Front end: config registers, load pointers and raster counters.
// Classifies each beat into a store or emit command for the queue. Uses nfa_pkg.
module nfa_front
    import nfa_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int ENTRY_W    = entry_bits(addr_bits(MAX_WIDTH * MAX_HEIGHT),
                                          addr_bits((MAX_WIDTH / 2) * (MAX_HEIGHT / 2)))
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,
    input  logic                  q_full,
    output logic                  q_push,
    output logic [ENTRY_W-1:0]    q_entry
);

    localparam int WW           = $clog2(MAX_WIDTH + 1);
    localparam int HW           = $clog2(MAX_HEIGHT + 1);
    localparam int LUMA_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CHROMA_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int LA           = addr_bits(LUMA_DEPTH);
    localparam int CA           = addr_bits(CHROMA_DEPTH);
    localparam int CPW          = CA + 1;
    localparam int AREA_W       = $clog2(LUMA_DEPTH + 1);
    localparam int W_RST        = fit_size(RST_WIDTH, MAX_WIDTH);
    localparam int H_RST        = fit_size(RST_HEIGHT, MAX_HEIGHT);

    typedef struct packed {
        cmd_kind_t     kind;
        logic [LA-1:0] luma_addr;
        logic [CA-1:0] chroma_idx;
        logic          chroma_bank;
        logic [7:0]    data;
        logic          last;
    } entry_t;

    logic [WW-1:0]     w_reg;
    logic [HW-1:0]     h_reg;
    logic [AREA_W-1:0] area_reg;
    logic              settle_reg;

    logic              in_chroma_reg, in_chroma_next;
    logic [LA-1:0]     luma_ptr_reg, luma_ptr_next;
    logic [CPW-1:0]    chroma_ptr_reg, chroma_ptr_next;
    logic [WW-1:0]     col_reg, col_next;
    logic [HW-1:0]     row_reg, row_next;
    logic [LA-1:0]     luma_base_reg, luma_base_next;
    logic [CA-1:0]     chroma_base_reg, chroma_base_next;

    logic              cfg_fire;
    logic [WW-1:0]     w_fit;
    logic [HW-1:0]     h_fit;
    logic              col_wrap;
    logic              row_wrap;
    logic              luma_done;
    logic              chroma_done;
    entry_t            entry;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign w_fit     = WW'(fit_size(int'(cfg_data), MAX_WIDTH));
    assign h_fit     = HW'(fit_size(int'(cfg_data), MAX_HEIGHT));

    // area is registered off the multiplier; hold input in the cycle after a write
    assign s_tready = ~q_full & ~settle_reg;
    assign q_push   = s_tvalid & s_tready;
    assign q_entry  = ENTRY_W'(entry);

    assign col_wrap    = (col_reg + WW'(1)) == w_reg;
    assign row_wrap    = (row_reg + HW'(1)) == h_reg;
    assign luma_done   = (AREA_W'(luma_ptr_reg) + AREA_W'(1)) == area_reg;
    assign chroma_done = (AREA_W'(chroma_ptr_reg) + AREA_W'(1)) == (area_reg >> 1);

    always_comb
    begin
        entry             = '0;
        entry.data        = s_tdata;
        entry.chroma_bank = chroma_ptr_reg[0];
        if (s_tuser == OP_EMIT)
        begin
            entry.kind       = CMD_EMIT;
            entry.luma_addr  = luma_base_reg + LA'(col_reg);
            entry.chroma_idx = chroma_base_reg + CA'(col_reg >> 1);
            entry.last       = col_wrap & row_wrap;
        end
        else if (in_chroma_reg)
        begin
            entry.kind       = CMD_CHROMA_WR;
            entry.chroma_idx = chroma_ptr_reg[CPW-1:1];
        end
        else
        begin
            entry.kind      = CMD_LUMA_WR;
            entry.luma_addr = luma_ptr_reg;
        end
    end

    always_comb
    begin
        in_chroma_next   = in_chroma_reg;
        luma_ptr_next    = luma_ptr_reg;
        chroma_ptr_next  = chroma_ptr_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        luma_base_next   = luma_base_reg;
        chroma_base_next = chroma_base_reg;
        if (cfg_fire)
        begin
            in_chroma_next   = 1'b0;
            luma_ptr_next    = '0;
            chroma_ptr_next  = '0;
            col_next         = '0;
            row_next         = '0;
            luma_base_next   = '0;
            chroma_base_next = '0;
        end
        else if (q_push && s_tuser == OP_EMIT)
        begin
            col_next = col_reg + WW'(1);
            if (col_wrap)
            begin
                col_next = '0;
                if (row_wrap)
                begin
                    row_next         = '0;
                    luma_base_next   = '0;
                    chroma_base_next = '0;
                end
                else
                begin
                    row_next       = row_reg + HW'(1);
                    luma_base_next = luma_base_reg + LA'(w_reg);
                    // chroma row advances after each odd luma row
                    if (row_reg[0])
                        chroma_base_next = chroma_base_reg + CA'(w_reg >> 1);
                end
            end
        end
        else if (q_push)
        begin
            if (in_chroma_reg)
            begin
                chroma_ptr_next = chroma_ptr_reg + CPW'(1);
                if (chroma_done)
                begin
                    chroma_ptr_next = '0;
                    in_chroma_next  = 1'b0;
                end
            end
            else
            begin
                luma_ptr_next = luma_ptr_reg + LA'(1);
                if (luma_done)
                begin
                    luma_ptr_next  = '0;
                    in_chroma_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg           <= WW'(W_RST);
            h_reg           <= HW'(H_RST);
            area_reg        <= AREA_W'(W_RST * H_RST);
            settle_reg      <= 1'b0;
            in_chroma_reg   <= 1'b0;
            luma_ptr_reg    <= '0;
            chroma_ptr_reg  <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            luma_base_reg   <= '0;
            chroma_base_reg <= '0;
        end
        else
        begin
            if (cfg_fire && cfg_index == REG_FRAME_WIDTH)
                w_reg <= w_fit;
            if (cfg_fire && cfg_index == REG_FRAME_HEIGHT)
                h_reg <= h_fit;
            area_reg        <= AREA_W'(w_reg * h_reg);
            settle_reg      <= cfg_fire;
            in_chroma_reg   <= in_chroma_next;
            luma_ptr_reg    <= luma_ptr_next;
            chroma_ptr_reg  <= chroma_ptr_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            luma_base_reg   <= luma_base_next;
            chroma_base_reg <= chroma_base_next;
        end
    end

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < w_reg)
        else $error("raster column beyond frame width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < h_reg)
        else $error("raster row beyond frame height");

    a_luma_ptr_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (!settle_reg && !in_chroma_reg) |-> (AREA_W'(luma_ptr_reg) < area_reg))
        else $error("luma load pointer beyond luma plane");

endmodule

>>> design/nfa_cmd_fifo.sv
// Small command queue between front and back ends.
// Register based, one write and one read per cycle. Uses nfa_pkg.
module nfa_cmd_fifo
    import nfa_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);

    localparam int PTR_W = addr_bits(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/nfa_back.sv
// Back end: banked luma / Cb / Cr stores, read stage, color convert, output register.
// Executes queued store and emit commands in order. Uses nfa_pkg.
module nfa_back
    import nfa_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int ENTRY_W    = entry_bits(addr_bits(MAX_WIDTH * MAX_HEIGHT),
                                          addr_bits((MAX_WIDTH / 2) * (MAX_HEIGHT / 2)))
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  logic [ENTRY_W-1:0] q_entry,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tlast
);

    localparam int LUMA_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CHROMA_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int LA           = addr_bits(LUMA_DEPTH);
    localparam int CA           = addr_bits(CHROMA_DEPTH);

    typedef struct packed {
        cmd_kind_t     kind;
        logic [LA-1:0] luma_addr;
        logic [CA-1:0] chroma_idx;
        logic          chroma_bank;
        logic [7:0]    data;
        logic          last;
    } entry_t;

    function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
        if (v < 0)
            return 8'h00;
        else if (v > 12'sd255)
            return 8'hFF;
        else
            return v[7:0];
    endfunction

    function automatic logic [31:0] yuv_to_argb(input logic [7:0] y_b,
                                                input logic [7:0] cb_b,
                                                input logic [7:0] cr_b);
        logic signed [11:0] ys;
        logic signed [11:0] cb;
        logic signed [11:0] cr;
        logic signed [11:0] r;
        logic signed [11:0] g;
        logic signed [11:0] b;
        ys = $signed({4'b0, y_b});
        cb = $signed({4'b0, cb_b}) - CHROMA_BIAS;
        cr = $signed({4'b0, cr_b}) - CHROMA_BIAS;
        r  = ys + cr + (cr >>> 2) + (cr >>> 3) + (cr >>> 5);
        g  = ys - (cb >>> 2) + (cb >>> 4) + (cb >>> 5)
           - (cr >>> 1) + (cr >>> 3) + (cr >>> 4) + (cr >>> 5);
        b  = ys + cb + (cb >>> 1) + (cb >>> 2) + (cb >>> 6);
        return {ALPHA, clamp_byte(b), clamp_byte(g), clamp_byte(r)};
    endfunction

    logic [7:0] luma_mem [LUMA_DEPTH];
    logic [7:0] cb_mem   [CHROMA_DEPTH];
    logic [7:0] cr_mem   [CHROMA_DEPTH];

    entry_t      head;
    logic        out_take;
    logic        s1_free;
    logic        emit_pop;
    logic        s1_vld_reg, s1_vld_next;
    logic        s1_last_reg;
    logic [7:0]  y_reg;
    logic [7:0]  cb_reg;
    logic [7:0]  cr_reg;
    logic        out_vld_reg;
    logic [31:0] out_word_reg;
    logic        out_last_reg;

    assign head     = entry_t'(q_entry);
    assign out_take = ~out_vld_reg | m_tready;
    assign s1_free  = ~s1_vld_reg | out_take;
    // stores never wait on the output side
    assign q_pop    = ~q_empty & ((head.kind != CMD_EMIT) | s1_free);
    assign emit_pop = q_pop & (head.kind == CMD_EMIT);

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_word_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop && head.kind == CMD_LUMA_WR)
            luma_mem[head.luma_addr] <= head.data;
        if (emit_pop)
            y_reg <= luma_mem[head.luma_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && head.kind == CMD_CHROMA_WR && !head.chroma_bank)
            cb_mem[head.chroma_idx] <= head.data;
        if (emit_pop)
            cb_reg <= cb_mem[head.chroma_idx];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && head.kind == CMD_CHROMA_WR && head.chroma_bank)
            cr_mem[head.chroma_idx] <= head.data;
        if (emit_pop)
            cr_reg <= cr_mem[head.chroma_idx];
    end

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (emit_pop)
            s1_vld_next = 1'b1;
        else if (out_take)
            s1_vld_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_pop)
            s1_last_reg <= head.last;
        if (out_take && s1_vld_reg)
        begin
            out_word_reg <= yuv_to_argb(y_reg, cb_reg, cr_reg);
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            if (out_take)
                out_vld_reg <= s1_vld_reg;
        end
    end

    a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !out_take) |=>
            (s1_vld_reg && $stable(y_reg) && $stable(cb_reg) && $stable(cr_reg)))
        else $error("read stage lost or changed a stalled pixel");

    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_word_reg[31:24] == ALPHA))
        else $error("output beat without opaque alpha");

endmodule

>>> design/nv21_frame_to_argb_converter.sv
// Top level of the NV21 to ARGB converter: front end, command queue, back end.
// Depends on nfa_pkg, nfa_front, nfa_cmd_fifo and nfa_back.
//
// Load one NV21 frame with store beats (s_tuser = 0, byte in s_tdata): the luma plane,
// then the interleaved Cb/Cr plane; the load pointer wraps after width*height*3/2 bytes.
// Each emit beat (s_tuser = 1) returns the next pixel in raster order as 0xFF,B,G,R,
// with m_tlast on the last pixel of the frame. The block takes one beat per cycle while
// the queue has room, stores and emits alike, limited by the single write and single
// read port of each of the luma, Cb and Cr banks; a pixel passes the queue, read stage
// and output register. A configuration write resets the load and raster positions and
// holds s_tready low for one cycle while the frame area is recomputed by the width by
// height multiplier. The frame store has no reset or clearing pass: load before emit.
module nv21_frame_to_argb_converter
    import nfa_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] frame_byte
    input  logic                  s_tuser,   // [0] op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [31:0] pixel_word
    output logic                  m_tlast
);

    localparam int LA      = addr_bits(MAX_WIDTH * MAX_HEIGHT);
    localparam int CA      = addr_bits((MAX_WIDTH / 2) * (MAX_HEIGHT / 2));
    localparam int ENTRY_W = entry_bits(LA, CA);

    logic               q_push;
    logic [ENTRY_W-1:0] q_entry;
    logic               q_full;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_head;
    logic               q_empty;

    nfa_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    nfa_cmd_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    nfa_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_entry  (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> sim/tb_nv21_frame_to_argb_converter.sv
// Self-checking testbench for nv21_frame_to_argb_converter: directed frames, then random
// loads and emits over several frame sizes and handshake pressure levels.
// Depends on nfa_pkg and the converter RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb_nv21_frame_to_argb_converter;
    import nfa_pkg::*;

    localparam int PIPE_FLUSH  = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } pixel_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  data;
        logic        known;
        logic [31:0] word;
        logic        last;
    } dir_row_t;

    // 2x2 frames: neutral chroma, then chroma at both extremes (clamping on all channels)
    localparam dir_row_t DIR_TAB [26] = '{
        '{OP_STORE, 8'h00, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'hFF, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'hFF, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'h00, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'h80, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'h80, 1'b0, 32'h0, 1'b0},
        '{OP_EMIT,  8'h00, 1'b1, 32'hFF000000, 1'b0},
        '{OP_EMIT,  8'h00, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{OP_EMIT,  8'h00, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{OP_EMIT,  8'h00, 1'b1, 32'hFF000000, 1'b1},
        // load pointer has wrapped: next frame
        '{OP_STORE, 8'hFF, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'h00, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'h00, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'hFF, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'hFF, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'hFF, 1'b0, 32'h0, 1'b0},
        '{OP_EMIT,  8'h00, 1'b1, 32'hFFFFC4FF, 1'b0},
        '{OP_EMIT,  8'h00, 1'b1, 32'hFFDE00B0, 1'b0},
        '{OP_STORE, 8'h00, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'h00, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'h00, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'hFF, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'h00, 1'b0, 32'h0, 1'b0},
        '{OP_STORE, 8'h00, 1'b0, 32'h0, 1'b0},
        '{OP_EMIT,  8'h00, 1'b1, 32'hFF003800, 1'b0},
        '{OP_EMIT,  8'h00, 1'b1, 32'hFF1DFF4B, 1'b1}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = OP_STORE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tlast;

    // shadow of the converter state
    int unsigned frame_w  = RST_WIDTH;
    int unsigned frame_h  = RST_HEIGHT;
    int unsigned load_ptr = 0;
    int unsigned pix_col  = 0;
    int unsigned pix_row  = 0;
    logic [7:0]  frame_img [int unsigned];

    pixel_t pending_pixels [$];
    pixel_t got_want;

    int err_cnt    = 0;
    int beats_sent = 0;
    int src_idle   = 0;
    int snk_stall  = 0;
    int hold_left  = 0;
    int cycle_cnt  = 0;
    bit burst_req  = 1'b0;
    bit burst_ack  = 1'b0;

    nv21_frame_to_argb_converter #(
        .MAX_WIDTH  (DEF_MAX_WIDTH),
        .MAX_HEIGHT (DEF_MAX_HEIGHT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic int unsigned fit_dim(input logic [CFG_DATA_W-1:0] raw,
                                            input int unsigned maxv);
        int unsigned v;
        v = raw;
        if (v < 2)
            v = 2;
        else if (v > maxv)
            v = maxv;
        v = v & ~32'd1;
        return v;
    endfunction

    function automatic logic [7:0] sat8(input int v);
        if (v < 0)
            return 8'h00;
        if (v > 255)
            return 8'hFF;
        return v[7:0];
    endfunction

    function automatic logic [7:0] img_at(input int unsigned addr);
        return frame_img.exists(addr) ? frame_img[addr] : 8'h00;
    endfunction

    function automatic int unsigned chroma_addr();
        return frame_w * frame_h + (pix_row >> 1) * frame_w + (pix_col & ~32'd1);
    endfunction

    // shift-add YCbCr to RGB; >>> on int is an arithmetic shift
    function automatic pixel_t argb_of(input int unsigned y_addr, input int unsigned c_addr);
        int     y;
        int     cb;
        int     cr;
        int     r;
        int     g;
        int     b;
        pixel_t px;
        y  = img_at(y_addr);
        cb = int'(img_at(c_addr)) - int'(CHROMA_BIAS);
        cr = int'(img_at(c_addr + 1)) - int'(CHROMA_BIAS);
        r  = y + cr + (cr >>> 2) + (cr >>> 3) + (cr >>> 5);
        g  = y - (cb >>> 2) + (cb >>> 4) + (cb >>> 5)
               - (cr >>> 1) + (cr >>> 3) + (cr >>> 4) + (cr >>> 5);
        b  = y + cb + (cb >>> 1) + (cb >>> 2) + (cb >>> 6);
        px.word = {ALPHA, sat8(b), sat8(g), sat8(r)};
        px.last = 1'b0;
        return px;
    endfunction

    // an emit may only read bytes loaded since the last register write
    function automatic bit pixel_loaded();
        int unsigned c_addr;
        c_addr = chroma_addr();
        return frame_img.exists(pix_row * frame_w + pix_col)
            && frame_img.exists(c_addr) && frame_img.exists(c_addr + 1);
    endfunction

    task automatic convert_beat(input logic op, input logic [7:0] data,
                                output bit has_px, output pixel_t px);
        int unsigned area;
        area   = frame_w * frame_h;
        has_px = 1'b0;
        px     = '0;
        if (op == OP_STORE) begin
            frame_img[load_ptr] = data;
            load_ptr++;
            if (load_ptr >= area + area / 2)
                load_ptr = 0;
        end
        else begin
            px = argb_of(pix_row * frame_w + pix_col, chroma_addr());
            pix_col++;
            if (pix_col >= frame_w) begin
                pix_col = 0;
                pix_row++;
                if (pix_row >= frame_h) begin
                    pix_row = 0;
                    px.last = 1'b1;
                end
            end
            has_px = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_cnt < PRINT_CAP)
            $display("mismatch %s: got %h, expected %h at cycle %0d",
                     what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    task automatic send_beat(input logic op, input logic [7:0] data,
                             input bit known, input pixel_t want);
        bit     has_px;
        pixel_t px;
        if ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        convert_beat(op, data, has_px, px);
        if (has_px)
            pending_pixels.push_back(known ? want : px);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            frame_w = fit_dim(val, DEF_MAX_WIDTH);
        else
            frame_h = fit_dim(val, DEF_MAX_HEIGHT);
        load_ptr = 0;
        pix_col  = 0;
        pix_row  = 0;
        // store layout moves with the size: treat old bytes as unloaded
        frame_img.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_FLUSH) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly whole-frame loads followed by a run of emits, with some scattered beats
    task automatic run_phase(input logic [CFG_DATA_W-1:0] w_raw,
                             input logic [CFG_DATA_W-1:0] h_raw,
                             input int src_pct, input int snk_pct,
                             input bit burst, input int budget);
        int unsigned area;
        int unsigned total;
        int unsigned n_emit;
        int          stop_at;
        bit          first;
        write_reg(REG_FRAME_WIDTH, w_raw);
        write_reg(REG_FRAME_HEIGHT, h_raw);
        src_idle  = src_pct;
        snk_stall <= snk_pct;
        area      = frame_w * frame_h;
        total     = area + area / 2;
        stop_at   = beats_sent + budget;
        first     = 1'b1;
        while (beats_sent < stop_at) begin
            if (first || $urandom_range(3) != 0) begin
                repeat (total) send_beat(OP_STORE, rand_byte(), 1'b0, '0);
                if (first && burst)
                    burst_req <= ~burst_req;
                n_emit = (area > 256) ? area : $urandom_range(1, 2 * area);
                repeat (n_emit) send_beat(OP_EMIT, rand_byte(), 1'b0, '0);
            end
            else begin
                repeat ($urandom_range(1, 6))
                    send_beat(($urandom_range(1) == 1 && pixel_loaded()) ? OP_EMIT : OP_STORE,
                              rand_byte(), 1'b0, '0);
            end
            first = 1'b0;
        end
        drain();
    endtask

    // receiver: random stalls, plus one long hold-off per burst request
    always @(posedge clk) begin
        if (burst_req != burst_ack) begin
            burst_ack <= burst_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(99) >= snk_stall);
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected pixel beat", m_tdata, 32'h0);
            end
            else begin
                got_want = pending_pixels.pop_front();
                if (m_tdata !== got_want.word)
                    report_mismatch("pixel_word", m_tdata, got_want.word);
                if (m_tlast !== got_want.last)
                    report_mismatch("end_of_frame", {31'b0, m_tlast}, {31'b0, got_want.last});
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_nv21_frame_to_argb_converter failed");
            $finish;
        end
    end

    initial begin
        pixel_t want;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_FRAME_WIDTH, 11'd2);
        write_reg(REG_FRAME_HEIGHT, 11'd2);
        for (int i = 0; i < $size(DIR_TAB); i++) begin
            want = {DIR_TAB[i].word, DIR_TAB[i].last};
            send_beat(DIR_TAB[i].op, DIR_TAB[i].data, DIR_TAB[i].known, want);
        end
        drain();

        // size extremes: out-of-range writes clamp to 1024 wide / 2 high and back
        run_phase(11'd2047, 11'd0, 0, 0, 1'b0, 1);
        run_phase(11'd1, 11'd1024, 0, 0, 1'b0, 1);
        run_phase(11'd6, 11'd4, 76, 0, 1'b0, 170);
        run_phase(11'd7, 11'd5, 0, 76, 1'b1, 170);
        run_phase(11'd16, 11'd8, 38, 38, 1'b0, 170);
        run_phase(11'd3, 11'd2, 76, 0, 1'b0, 170);
        run_phase(11'd10, 11'd6, 0, 0, 1'b0, 170);
        run_phase(11'd4, 11'd12, 0, 76, 1'b0, 170);
        run_phase(11'd8, 11'd8, 38, 38, 1'b1, 170);
        run_phase(11'd2, 11'd2, 0, 0, 1'b0, 150);

        if (err_cnt == 0 && pending_pixels.size() == 0)
            $display("tb_nv21_frame_to_argb_converter passed");
        else
            $display("tb_nv21_frame_to_argb_converter failed");
        $finish;
    end

endmodule
